@@ hdl/sknn_pkg.sv @@
// ============================================================================
// sknn_pkg: shared constants and types for the k-nearest selector
// Holds the store geometry, register codes, command function codes and the RAM request type.
// ============================================================================
package sknn_pkg;
    localparam int unsigned K_MAX   = 32;
    localparam int unsigned AW      = $clog2(K_MAX);
    localparam int unsigned CW      = $clog2(K_MAX + 1);
    localparam int unsigned EW      = 64;

    localparam logic [0:0] REG_K_LIMIT = 1'd0;
    localparam logic [0:0] REG_SKIP    = 1'd1;

    localparam logic FUNC_OFFER = 1'b0;
    localparam logic FUNC_END   = 1'b1;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [EW-1:0] wdata;
        logic [AW-1:0] raddr;
    } t_mem_req;
endpackage

@@ hdl/sknn_ram.sv @@
// ============================================================================
// sknn_ram: entry store
// One write port, one read port with a registered read.
// ============================================================================
module sknn_ram (
    input  logic                  i_clk,
    input  sknn_pkg::t_mem_req    i_req,
    output logic [sknn_pkg::EW-1:0] o_rdata
);
    logic [sknn_pkg::EW-1:0] r_mem [sknn_pkg::K_MAX];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr];
    end
endmodule

@@ hdl/streaming_k_nearest_select.sv @@
// ============================================================================
// streaming_k_nearest_select: keeps the k closest candidates to a query
// Sorted list in one RAM; insertion shifts entries up one at a time while busy is held.
// ============================================================================
// channel   direction  handshake                 words
// command   in         start & !busy             func, id, distance, flags
// result    out        o_strobe (one cycle)      id, distance, last, empty
// config    in         APB write, pready = 1     k_limit, skip_connected
//
// An offer dropped by its flags goes straight back to idle; an offer
// rejected by a full store ends after a read of the tail entry. An insertion
// walks the list from the tail down, a RAM read then a write per entry moved.
// A drain reads each entry through the store's read port and then shows it
// as a result word, the final one with last; an empty drain shows empty.
// Reset clears count, registers and sequencer; RAM contents are not cleared.
// Results cannot be stalled; the block holds busy until a drain completes.
// ============================================================================
module streaming_k_nearest_select (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [31:0] i_vertex_id,
    input  logic [31:0] i_distance,
    input  logic        i_dist_infinite,
    input  logic        i_is_self,
    input  logic        i_already_connected,
    output logic        o_strobe,
    output logic [31:0] o_neighbor_id,
    output logic [31:0] o_neighbor_distance,
    output logic        o_last,
    output logic        o_empty_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned AW = sknn_pkg::AW;
    localparam int unsigned CW = sknn_pkg::CW;
    localparam int unsigned EW = sknn_pkg::EW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_TAIL  = 3'd1;  // tail read in flight
    localparam logic [2:0] S_SRD   = 3'd2;  // shift: read pos-1 issued
    localparam logic [2:0] S_SCMP  = 3'd3;  // shift: compare / move
    localparam logic [2:0] S_DRD   = 3'd4;  // drain read in flight
    localparam logic [2:0] S_DOUT  = 3'd5;

    logic [5:0]  r_k_limit;
    logic        r_skip;
    logic [2:0]  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pos, n_pos;
    logic [EW-1:0] r_key;
    logic [EW-1:0] w_rdata;
    sknn_pkg::t_mem_req w_req;
    logic [CW-1:0] w_k;
    logic          w_wr;
    logic [AW-1:0] w_paddr_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_paddr_idx = '0;
    assign w_k = (r_k_limit == 6'd0 || {1'b0, r_k_limit} > 7'(sknn_pkg::K_MAX))
                 ? CW'(sknn_pkg::K_MAX) : CW'(r_k_limit);

    always_comb begin
        case (paddr[2])
            sknn_pkg::REG_K_LIMIT: prdata = {26'd0, r_k_limit};
            sknn_pkg::REG_SKIP:    prdata = {31'd0, r_skip};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_limit <= '0;
            r_skip    <= 1'b0;
        end else if (w_wr && paddr[1:0] == 2'd0) begin
            if (paddr[2] == sknn_pkg::REG_K_LIMIT) r_k_limit <= pwdata[5:0];
            else                                   r_skip    <= pwdata[0];
        end
    end

    sknn_ram u_ram (.i_clk(i_clk), .i_req(w_req), .o_rdata(w_rdata));

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        w_req.we    = 1'b0;
        w_req.waddr = w_paddr_idx;
        w_req.wdata = r_key;
        w_req.raddr = w_paddr_idx;
        case (r_state)
            S_IDLE: begin
                w_req.raddr = AW'(r_count - CW'(1));
                if (start) begin
                    if (i_func == sknn_pkg::FUNC_END) begin
                        n_pos = '0;
                        if (r_count == '0) n_state = S_DOUT;
                        else begin
                            w_req.raddr = '0;
                            n_state = S_DRD;
                        end
                    end else if (!(i_is_self || i_dist_infinite ||
                                   (r_skip && i_already_connected))) begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_TAIL: begin
                // tail entry on w_rdata
                if (r_count < w_k) begin
                    n_pos = r_count;
                    n_count = r_count + CW'(1);
                    n_state = S_SRD;
                end else if (r_count != '0 && r_key[63:32] < w_rdata[63:32]) begin
                    n_pos = r_count - CW'(1);
                    n_state = S_SRD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SRD: begin
                if (r_pos == '0) begin
                    w_req.we = 1'b1;
                    w_req.waddr = '0;
                    n_state = S_IDLE;
                end else begin
                    w_req.raddr = AW'(r_pos - CW'(1));
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (w_rdata > r_key) begin
                    w_req.we = 1'b1;
                    w_req.waddr = AW'(r_pos);
                    w_req.wdata = w_rdata;
                    n_pos = r_pos - CW'(1);
                    n_state = S_SRD;
                end else begin
                    w_req.we = 1'b1;
                    w_req.waddr = AW'(r_pos);
                    n_state = S_IDLE;
                end
            end
            S_DRD: begin
                w_req.raddr = AW'(r_pos);
                n_state = S_DOUT;
            end
            S_DOUT: begin
                n_pos = r_pos + CW'(1);
                w_req.raddr = AW'(r_pos + CW'(1));
                if (r_count == '0 || r_pos + CW'(1) == r_count) begin
                    n_count = '0;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_DRD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) r_key <= {i_distance, i_vertex_id};
    end

    // result word shown in S_DOUT; read data still valid (read re-issued in DRD)
    assign o_strobe            = (r_state == S_DOUT);
    assign o_empty_res         = (r_state == S_DOUT) && (r_count == '0);
    assign o_neighbor_id       = (r_count == '0) ? 32'd0 : w_rdata[31:0];
    assign o_neighbor_distance = (r_count == '0) ? 32'd0 : w_rdata[63:32];
    assign o_last = (r_state == S_DOUT) && (r_count != '0) &&
                    (r_pos + CW'(1) == r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(sknn_pkg::K_MAX))
        else $error("count above capacity");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_last || o_empty_res) |=> (r_state == S_IDLE && r_count == '0))
        else $error("drain end did not empty store");
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result outside busy");
endmodule

@@ sim/streaming_k_nearest_select_tb.sv @@
// ============================================================================
// streaming_k_nearest_select_tb: self-checking bench for the k-nearest selector
// Drives offers and end words through the start/busy port, predicts the sorted
// drain with a local sorted-list model, and checks every strobed result.
// ============================================================================
module streaming_k_nearest_select_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] id;
        logic [31:0] nbr_dist;
        logic        last;
        logic        empty;
    } t_nbr;

    // Scoreboard: sorted list of kept (distance,id) keys plus pending drain words.
    class knn_board;
        logic [63:0] kept[$];
        t_nbr        pending[$];
        int unsigned k_reg;
        bit          skip_conn;
        int          errors;

        function void note_word(logic func, logic [31:0] id, logic [31:0] cand_dist,
                                logic inf, logic self_c, logic conn);
            logic [63:0] key;
            int unsigned keff;
            int          pos;
            t_nbr        r;
            key  = {cand_dist, id};
            keff = (k_reg == 0 || k_reg > sknn_pkg::K_MAX) ? sknn_pkg::K_MAX : k_reg;
            if (func == sknn_pkg::FUNC_OFFER) begin
                if (self_c || inf || (skip_conn && conn)) return;
                if (kept.size() < keff) begin
                end else if (kept.size() > 0 && cand_dist < kept[$][63:32]) begin
                    void'(kept.pop_back());
                end else begin
                    return;
                end
                pos = kept.size();
                while (pos > 0 && kept[pos-1] > key) pos--;
                kept.insert(pos, key);
            end else begin
                if (kept.size() == 0) begin
                    r = '{32'd0, 32'd0, 1'b0, 1'b1};
                    pending = {pending, r};
                end
                foreach (kept[i]) begin
                    r = '{kept[i][31:0], kept[i][63:32], i == kept.size() - 1, 1'b0};
                    pending = {pending, r};
                end
                kept.delete();
            end
        endfunction

        function void check_word(t_nbr got);
            t_nbr exp;
            if (pending.size() == 0) begin
                $error("unexpected result id=%h", got.id);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.id !== exp.id) begin
                $error("neighbor_id exp %h got %h", exp.id, got.id); errors++;
            end
            if (got.nbr_dist !== exp.nbr_dist) begin
                $error("neighbor_distance exp %h got %h", exp.nbr_dist, got.nbr_dist);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last exp %b got %b", exp.last, got.last); errors++;
            end
            if (got.empty !== exp.empty) begin
                $error("empty_res exp %b got %b", exp.empty, got.empty); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_func = 1'b0;
    logic [31:0] i_vertex_id = '0;
    logic [31:0] i_distance = '0;
    logic        i_dist_infinite = 1'b0;
    logic        i_is_self = 1'b0;
    logic        i_already_connected = 1'b0;
    logic        o_strobe;
    logic [31:0] o_neighbor_id;
    logic [31:0] o_neighbor_distance;
    logic        o_last;
    logic        o_empty_res;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    knn_board board = new();

    streaming_k_nearest_select u_top (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Results cannot be stalled: sample every strobe at the edge that ends it.
    always @(posedge i_clk) begin
        t_nbr got;
        if (i_rst_n && o_strobe) begin
            got = '{o_neighbor_id, o_neighbor_distance, o_last, o_empty_res};
            board.check_word(got);
        end
    end

    // APB write: setup cycle, then access cycle (pready is tied high).
    task automatic reg_write(logic [0:0] idx, logic [31:0] val);
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == sknn_pkg::REG_K_LIMIT) board.k_reg = val[5:0];
        else board.skip_conn = val[0];
    endtask

    // Wait for all expected drain words, then idle past the longest insertion.
    task automatic wait_idle();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (2 * sknn_pkg::K_MAX + 8) @(posedge i_clk);
    endtask

    // One command word; start stays high across back-to-back words.
    task automatic send_word(logic func, logic [31:0] id, logic [31:0] cand_dist,
                             logic inf, logic self_c, logic conn, bit hold);
        start               <= 1'b1;
        i_func              <= func;
        i_vertex_id         <= id;
        i_distance          <= cand_dist;
        i_dist_infinite     <= inf;
        i_is_self           <= self_c;
        i_already_connected <= conn;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_word(func, id, cand_dist, inf, self_c, conn);
        if (!hold) start <= 1'b0;
    endtask

    // Random gap between bursts (no gap inside a burst).
    int burst_left = 0;
    task automatic rnd_send(logic func, logic [31:0] id, logic [31:0] cand_dist,
                            logic inf, logic self_c, logic conn);
        bit gap;
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        burst_left--;
        gap = (burst_left == 0);
        send_word(func, id, cand_dist, inf, self_c, conn, !gap);
        if (gap) repeat ($urandom_range(1, 6)) @(posedge i_clk);
    endtask

    task automatic rnd_query(int n_offers, int dist_span);
        logic [31:0] d;
        for (int i = 0; i < n_offers; i++) begin
            d = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, dist_span);
            rnd_send(sknn_pkg::FUNC_OFFER, ($urandom_range(0, 3) == 0) ? $urandom()
                                                            : $urandom_range(0, 15),
                     d, $urandom_range(0, 11) == 0, $urandom_range(0, 11) == 0,
                     $urandom_range(0, 3) == 0);
        end
        rnd_send(sknn_pkg::FUNC_END, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int unsigned k_set[6];
        k_set = '{0, 1, 32, 5, 63, 3};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty drain, extremes, skips, ties, full-store replacement.
        reg_write(sknn_pkg::REG_K_LIMIT, 32'd2);
        reg_write(sknn_pkg::REG_SKIP, 32'd1);
        send_word(sknn_pkg::FUNC_END, '1, '1, 1, 1, 1, 0);
        send_word(sknn_pkg::FUNC_OFFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd0, 32'd0, 1, 0, 0, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd1, 32'd0, 0, 1, 0, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd2, 32'd0, 0, 0, 1, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd7, 32'h10, 0, 0, 0, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd3, 32'hFFFF_FFFF, 0, 0, 0, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd4, 32'h10, 0, 0, 0, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd0, 32'd0, 0, 0, 0, 1);
        send_word(sknn_pkg::FUNC_END, 32'd0, 32'd0, 0, 0, 0, 0);
        wait_idle();
        reg_write(sknn_pkg::REG_SKIP, 32'd0);
        reg_write(sknn_pkg::REG_K_LIMIT, 32'd0);
        send_word(sknn_pkg::FUNC_OFFER, 32'd9, 32'd5, 0, 0, 1, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd8, 32'd5, 0, 0, 1, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd1, 32'h8000_0000, 0, 0, 0, 0);
        wait_idle();
        // Lowered k mid-query: store keeps its three entries.
        reg_write(sknn_pkg::REG_K_LIMIT, 32'd1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd6, 32'd1, 0, 0, 0, 1);
        send_word(sknn_pkg::FUNC_OFFER, 32'd5, 32'd9, 0, 0, 0, 1);
        send_word(sknn_pkg::FUNC_END, 32'd0, 32'd0, 0, 0, 0, 0);
        wait_idle();

        // Random queries across several settings, extremes included.
        foreach (k_set[s]) begin
            reg_write(sknn_pkg::REG_K_LIMIT, k_set[s]);
            reg_write(sknn_pkg::REG_SKIP, $urandom_range(0, 1));
            for (int q = 0; q < 3; q++)
                rnd_query($urandom_range(0, (q == 2) ? 40 : 10),
                          (s % 2) ? 32'hFFFF : 32'd20);
            start <= 1'b0;
            wait_idle();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

@@ files.f @@
hdl/sknn_pkg.sv
hdl/sknn_ram.sv
hdl/streaming_k_nearest_select.sv
sim/streaming_k_nearest_select_tb.sv
